[hdl/avc_slice_type_sniffer_unit_defines.svh]
// Assertion macros for the slice type sniffer.
// Taken in by the modules that carry concurrent checks; they expect clk_i and rst_ni.
`ifndef AVC_SLICE_TYPE_SNIFFER_UNIT_DEFINES_SVH
`define AVC_SLICE_TYPE_SNIFFER_UNIT_DEFINES_SVH

// check a property at every edge outside reset
`define AVC_STS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition implies another in the next cycle
`define AVC_STS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/avc_sts_pkg.sv]
// Shared types and constants for the slice type sniffer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package avc_sts_pkg;

  localparam int unsigned WindowBytes = 8;
  localparam int unsigned WindowBits  = 8 * WindowBytes;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [2:0] LpbReset = 3'd4;

  localparam logic [4:0] NalTypeSlice = 5'd1;
  localparam logic [4:0] NalTypeIdr   = 5'd5;
  localparam logic [7:0] NalTypeMask  = 8'h1F;

  localparam logic [2:0] ClassNone  = 3'd0;
  localparam logic [2:0] ClassP     = 3'd1;
  localparam logic [2:0] ClassB     = 3'd2;
  localparam logic [2:0] ClassI     = 3'd3;
  localparam logic [2:0] ClassSp    = 3'd4;
  localparam logic [2:0] ClassSi    = 3'd5;
  localparam logic [2:0] ClassOther = 3'd6;
  localparam logic [2:0] ClassBad   = 3'd7;

  typedef enum logic [1:0] {
    VerdictNone,
    VerdictIdr,
    VerdictBad,
    VerdictCode
  } verdict_e;

  // outcome of one sample; for a decoded code, the zero run and suffix
  typedef struct packed {
    verdict_e    kind;
    logic [4:0]  zeros;
    logic [30:0] suffix;
  } verdict_t;

  typedef struct packed {
    logic     push;
    verdict_t entry;
  } qpush_t;

  typedef struct packed {
    logic     valid;
    verdict_t entry;
  } qhead_t;

endpackage

[hdl/avc_sts_if.sv]
// Handshake channels of the slice type sniffer: byte input and result output.
// Uses no package.
`timescale 1ns / 1ps

interface avc_sts_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample_byte;
  logic       end_of_sample;

  modport source (output valid, output sample_byte, output end_of_sample, input ready);
  modport sink   (input valid, input sample_byte, input end_of_sample, output ready);
endinterface

interface avc_sts_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  slice_class;
  logic [31:0] slice_type_code;

  modport source (output valid, output slice_class, output slice_type_code, input ready);
  modport sink   (input valid, input slice_class, input slice_type_code, output ready);
endinterface

[hdl/avc_sts_front.sv]
// Byte parser: length prefixes, unit skipping, header check and exp-Golomb window.
// Depends on avc_sts_pkg and avc_sts_byte_if; pushes one verdict per sample.
`timescale 1ns / 1ps

module avc_sts_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [2:0]             lpb_i,
  input  logic                   full_i,
  avc_sts_byte_if.sink           byte_i,
  output avc_sts_pkg::qpush_t    push_o
);

  localparam logic [2:0] PhPrefix = 3'd0;
  localparam logic [2:0] PhHeader = 3'd1;
  localparam logic [2:0] PhSkip   = 3'd2;
  localparam logic [2:0] PhWindow = 3'd3;
  localparam logic [2:0] PhDone   = 3'd4;

  localparam logic [6:0] WinInit = 7'(avc_sts_pkg::WindowBits);

  logic [2:0]  phase_q, phase_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] ulen_q, ulen_d;
  logic [31:0] skip_q, skip_d;
  logic        gidx_q, gidx_d;
  logic [6:0]  zrun_q, zrun_d;
  logic [31:0] acc_q, acc_d;
  logic        insfx_q, insfx_d;
  logic [6:0]  sleft_q, sleft_d;
  logic [6:0]  wleft_q, wleft_d;
  avc_sts_pkg::verdict_t dec_q, dec_d;
  logic        accept;

  assign byte_i.ready = !full_i;
  assign accept       = byte_i.valid && !full_i;

  always_comb begin
    logic [7:0]  b;
    logic [4:0]  ntype;
    logic [31:0] ulen_sh;
    logic        bt;
    logic        fin;
    b       = byte_i.sample_byte;
    ntype   = 5'(b & avc_sts_pkg::NalTypeMask);
    ulen_sh = {ulen_q[23:0], b};
    bt      = 1'b0;
    fin     = 1'b0;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    ulen_d  = ulen_q;
    skip_d  = skip_q;
    gidx_d  = gidx_q;
    zrun_d  = zrun_q;
    acc_d   = acc_q;
    insfx_d = insfx_q;
    sleft_d = sleft_q;
    wleft_d = wleft_q;
    dec_d   = dec_q;
    unique case (phase_q)
      PhPrefix: begin
        if (lpb_i != 3'd1 && lpb_i != 3'd2 && lpb_i != 3'd4) begin
          dec_d   = '{kind: avc_sts_pkg::VerdictNone, zeros: '0, suffix: '0};
          phase_d = PhDone;
        end else begin
          ulen_d = ulen_sh;
          if (({1'b0, cnt_q} + 3'd1) >= lpb_i) begin
            cnt_d = 2'd0;
            if (ulen_sh != 32'd0) begin
              phase_d = PhHeader;
            end
          end else begin
            cnt_d = cnt_q + 2'd1;
          end
        end
      end
      PhHeader: begin
        if (ntype == avc_sts_pkg::NalTypeIdr) begin
          dec_d   = '{kind: avc_sts_pkg::VerdictIdr, zeros: '0, suffix: '0};
          phase_d = PhDone;
        end else if (ntype == avc_sts_pkg::NalTypeSlice) begin
          gidx_d  = 1'b0;
          zrun_d  = 7'd0;
          acc_d   = 32'd0;
          insfx_d = 1'b0;
          sleft_d = 7'd0;
          wleft_d = WinInit;
          phase_d = PhWindow;
        end else begin
          skip_d  = ulen_q - 32'd1;
          ulen_d  = 32'd0;
          phase_d = (ulen_q == 32'd1) ? PhPrefix : PhSkip;
        end
      end
      PhSkip: begin
        skip_d = skip_q - 32'd1;
        if (skip_q == 32'd1) begin
          phase_d = PhPrefix;
        end
      end
      PhWindow: begin
        for (int unsigned i = 0; i < 8; i++) begin
          if (!fin) begin
            bt      = b[3'(7 - i)];
            wleft_d = wleft_d - 7'd1;
            if (insfx_d) begin
              acc_d   = {acc_d[30:0], bt};
              sleft_d = sleft_d - 7'd1;
              if (sleft_d == 7'd0) begin
                fin = 1'b1;
              end
            end else if (!bt) begin
              zrun_d = zrun_d + 7'd1;
            end else if (zrun_d == 7'd0) begin
              acc_d = 32'd0;
              fin   = 1'b1;
            end else begin
              insfx_d = 1'b1;
              sleft_d = zrun_d;
              acc_d   = 32'd0;
            end
            // end of the first code: restart for the slice type code
            if (fin && !gidx_d) begin
              fin     = 1'b0;
              gidx_d  = 1'b1;
              zrun_d  = 7'd0;
              acc_d   = 32'd0;
              insfx_d = 1'b0;
              sleft_d = 7'd0;
            end
          end
        end
        if (fin) begin
          dec_d   = '{kind: avc_sts_pkg::VerdictCode, zeros: zrun_d[4:0], suffix: acc_d[30:0]};
          phase_d = PhDone;
        end else if (wleft_d == 7'd0) begin
          dec_d   = '{kind: avc_sts_pkg::VerdictBad, zeros: '0, suffix: '0};
          phase_d = PhDone;
        end
      end
      PhDone: begin
      end
      default: begin
        phase_d = PhPrefix;
      end
    endcase

    push_o.push  = accept && byte_i.end_of_sample;
    push_o.entry = dec_d;
    if (phase_d == PhWindow) begin
      push_o.entry = '{kind: avc_sts_pkg::VerdictBad, zeros: '0, suffix: '0};
    end else if (phase_d != PhDone) begin
      push_o.entry = '{kind: avc_sts_pkg::VerdictNone, zeros: '0, suffix: '0};
    end

    if (byte_i.end_of_sample) begin
      phase_d = PhPrefix;
      cnt_d   = 2'd0;
      ulen_d  = 32'd0;
      skip_d  = 32'd0;
      gidx_d  = 1'b0;
      zrun_d  = 7'd0;
      acc_d   = 32'd0;
      insfx_d = 1'b0;
      sleft_d = 7'd0;
      wleft_d = WinInit;
      dec_d   = '{kind: avc_sts_pkg::VerdictNone, zeros: '0, suffix: '0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhPrefix;
      cnt_q   <= 2'd0;
      ulen_q  <= 32'd0;
      skip_q  <= 32'd0;
      gidx_q  <= 1'b0;
      zrun_q  <= 7'd0;
      acc_q   <= 32'd0;
      insfx_q <= 1'b0;
      sleft_q <= 7'd0;
      wleft_q <= WinInit;
      dec_q   <= '{kind: avc_sts_pkg::VerdictNone, zeros: '0, suffix: '0};
    end else if (accept) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      ulen_q  <= ulen_d;
      skip_q  <= skip_d;
      gidx_q  <= gidx_d;
      zrun_q  <= zrun_d;
      acc_q   <= acc_d;
      insfx_q <= insfx_d;
      sleft_q <= sleft_d;
      wleft_q <= wleft_d;
      dec_q   <= dec_d;
    end
  end

endmodule

[hdl/avc_sts_queue.sv]
// Two-entry verdict queue between the byte parser and the result stage.
// Depends on avc_sts_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "avc_slice_type_sniffer_unit_defines.svh"

module avc_sts_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  avc_sts_pkg::qpush_t push_i,
  input  logic                pop_i,
  output logic                full_o,
  output avc_sts_pkg::qhead_t head_o
);

  localparam int unsigned PtrW = $clog2(avc_sts_pkg::QueueDepth);
  localparam logic [PtrW:0] DepthC = (PtrW + 1)'(avc_sts_pkg::QueueDepth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(avc_sts_pkg::QueueDepth - 1);

  avc_sts_pkg::verdict_t entries_q [avc_sts_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;
  logic            empty, do_push, do_pop;

  assign empty   = (count_q == '0);
  assign full_o  = (count_q == DepthC);
  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && !empty;

  assign head_o.valid = !empty;
  assign head_o.entry = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `AVC_STS_ASSERT(a_count_bound, count_q <= DepthC, "queue count beyond depth")
  `AVC_STS_ASSERT(a_empty_ptrs, !empty || (rd_ptr_q == wr_ptr_q), "empty queue with split pointers")
  `AVC_STS_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_q == $past(count_q) + 1'b1, "push lost")

endmodule

[hdl/avc_sts_back.sv]
// Result stage: turns a queued verdict into slice class and code, held in an output register.
// Depends on avc_sts_pkg and avc_sts_result_if.
`timescale 1ns / 1ps

module avc_sts_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  avc_sts_pkg::qhead_t head_i,
  output logic                pop_o,
  avc_sts_result_if.source    result_o
);

  logic        valid_q;
  logic [2:0]  class_q, class_d;
  logic [31:0] code_q, code_d;
  logic [31:0] golomb;
  logic [2:0]  mapped;

  // value of a code: 2^zeros - 1 + suffix
  assign golomb = ((32'd1 << head_i.entry.zeros) - 32'd1) + {1'b0, head_i.entry.suffix};

  always_comb begin
    mapped = avc_sts_pkg::ClassOther;
    if (golomb <= 32'd9) begin
      unique case (golomb[3:0]) inside
        4'd0, 4'd5: mapped = avc_sts_pkg::ClassP;
        4'd1, 4'd6: mapped = avc_sts_pkg::ClassB;
        4'd2, 4'd7: mapped = avc_sts_pkg::ClassI;
        4'd3, 4'd8: mapped = avc_sts_pkg::ClassSp;
        4'd4, 4'd9: mapped = avc_sts_pkg::ClassSi;
        default:    mapped = avc_sts_pkg::ClassOther;
      endcase
    end
  end

  always_comb begin
    code_d = 32'd0;
    unique case (head_i.entry.kind)
      avc_sts_pkg::VerdictNone: class_d = avc_sts_pkg::ClassNone;
      avc_sts_pkg::VerdictIdr:  class_d = avc_sts_pkg::ClassI;
      avc_sts_pkg::VerdictBad:  class_d = avc_sts_pkg::ClassBad;
      avc_sts_pkg::VerdictCode: begin
        class_d = mapped;
        code_d  = golomb;
      end
      default: class_d = avc_sts_pkg::ClassNone;
    endcase
  end

  assign pop_o = head_i.valid && (!valid_q || result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || result_o.ready) begin
      valid_q <= head_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      class_q <= class_d;
      code_q  <= code_d;
    end
  end

  assign result_o.valid           = valid_q;
  assign result_o.slice_class     = class_q;
  assign result_o.slice_type_code = code_q;

endmodule

[hdl/avc_slice_type_sniffer_unit.sv]
// Slice type sniffer for length-prefixed H.264 samples, one byte per cycle. A byte is
// taken in every cycle while the two-entry verdict queue has room; the parser works the
// eight bits of a window byte in the same cycle, so nothing but a full queue stalls input.
// One result per sample, decided at its last byte, is written into the verdict queue and
// moves on into the output register once that is free, where it is valid on the output;
// the queue lets up to two finished results wait downstream.
// The prefix size register is written with cfg_we_i and applies from the next byte.
// Depends on avc_sts_pkg, the channel interfaces, avc_sts_front, avc_sts_queue, avc_sts_back.
`timescale 1ns / 1ps
`include "avc_slice_type_sniffer_unit_defines.svh"

module avc_slice_type_sniffer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i,
  avc_sts_byte_if.sink       byte_i,
  avc_sts_result_if.source   result_o
);

  logic                lpb_q;
  logic [2:0]          lpb_val_q;
  avc_sts_pkg::qpush_t push;
  avc_sts_pkg::qhead_t head;
  logic                full;
  logic                pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lpb_val_q <= avc_sts_pkg::LpbReset;
      lpb_q     <= 1'b0;
    end else if (cfg_we_i) begin
      lpb_val_q <= cfg_wdata_i;
      lpb_q     <= 1'b1;
    end
  end

  avc_sts_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .lpb_i  (lpb_val_q),
    .full_i (full),
    .byte_i (byte_i),
    .push_o (push)
  );

  avc_sts_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (full),
    .head_o (head)
  );

  avc_sts_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .pop_o    (pop),
    .result_o (result_o)
  );

  `AVC_STS_ASSERT(a_lpb_written, !lpb_q || $past(lpb_q) || $past(cfg_we_i), "prefix size flag set without a write")

endmodule
